>>> hw/rtl/rkc_pkg.sv
// Shared constants, codes and types of the RGB convolution block.
package rkc_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int MAX_KERNEL  = 7;
  localparam int WFRAC       = 16;

  localparam int LINE_DEPTH  = MAX_WIDTH * (MAX_KERNEL + 1);
  localparam int LINE_AW     = $clog2(LINE_DEPTH);
  localparam int TABLE_DEPTH = MAX_KERNEL * MAX_KERNEL;
  localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
  localparam int PIX_W       = 40;
  localparam int CNT_W       = 21;
  localparam int CRD_W       = 10;
  localparam int ACC_W       = 33;
  localparam int PROD_W      = 27;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_PIXEL = 2'd1;
  localparam logic [1:0] OP_DRAIN = 2'd2;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_KSIZE  = 2'd2;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_PIX  = 1'b1;

  typedef struct packed {
    logic [10:0] w;
    logic [10:0] h;
    logic [2:0]  ks;
    logic [1:0]  r;
  } cfg_t;

  typedef struct packed {
    logic                kind;
    logic [5:0]          widx;
    logic signed [17:0]  wval;
    logic [PIX_W-1:0]    pix;
    logic                store;
    logic [LINE_AW-1:0]  addr;
    logic                produce;
    logic [CRD_W-1:0]    px;
    logic [CRD_W-1:0]    py;
    logic                last;
  } cmd_t;

endpackage

>>> hw/rtl/rkc_if.sv
// Valid/ready channel interfaces for the input items and the results.
interface rkc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic [5:0]         weight_index;
  logic signed [17:0] weight_value;
  logic [7:0]         red_in;
  logic [7:0]         green_in;
  logic [7:0]         blue_in;
  logic [15:0]        side_in;

  modport source (output valid, operation, weight_index, weight_value, red_in, green_in,
                  blue_in, side_in, input ready);
  modport sink (input valid, operation, weight_index, weight_value, red_in, green_in,
                blue_in, side_in, output ready);
endinterface

interface rkc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  red_out;
  logic [7:0]  green_out;
  logic [7:0]  blue_out;
  logic [15:0] side_out;
  logic        frame_last;

  modport source (output valid, red_out, green_out, blue_out, side_out, frame_last,
                  input ready);
  modport sink (input valid, red_out, green_out, blue_out, side_out, frame_last,
                output ready);
endinterface

>>> hw/rtl/rkc_ram.sv
// Generic simple dual-port RAM with registered read data.
module rkc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> hw/rtl/rkc_front.sv
// Front end: configuration registers, frame counters and item classification.
module rkc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [10:0]         cfg_data,
  input  logic                acc_en,
  input  logic [1:0]          operation,
  input  logic [5:0]          weight_index,
  input  logic signed [17:0]  weight_value,
  input  logic [7:0]          red_in,
  input  logic [7:0]          green_in,
  input  logic [7:0]          blue_in,
  input  logic [15:0]         side_in,
  output rkc_pkg::cfg_t       cfg,
  output logic                push,
  output rkc_pkg::cmd_t       cmd
);
  import rkc_pkg::*;

  logic [10:0]      width_r, width_nxt, height_r, height_nxt;
  logic [2:0]       ksize_r, ksize_nxt;
  logic [CNT_W-1:0] recv_r, recv_nxt, emit_r, emit_nxt;
  logic [CRD_W-1:0] ex_r, ex_nxt, ey_r, ey_nxt;
  logic [21:0]      area;
  logic [CNT_W-1:0] total, lag, emit_inc;
  logic [12:0]      lag_s;
  logic             do_emit;

  always_comb begin
    cfg.w  = (width_r == 11'd0) ? 11'd1 :
             (width_r > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : width_r;
    cfg.h  = (height_r == 11'd0) ? 11'd1 :
             (height_r > 11'(MAX_HEIGHT)) ? 11'(MAX_HEIGHT) : height_r;
    cfg.ks = (ksize_r == 3'd0) ? 3'd1 : ksize_r;
    cfg.r  = cfg.ks[2:1];
  end

  assign area     = cfg.w * cfg.h;
  assign total    = area[CNT_W-1:0];
  assign lag_s    = 13'(cfg.r) * 13'(cfg.w) + 13'(cfg.r);
  assign lag      = CNT_W'(lag_s);
  assign emit_inc = emit_r + CNT_W'(1);

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    ksize_nxt  = ksize_r;
    recv_nxt   = recv_r;
    emit_nxt   = emit_r;
    ex_nxt     = ex_r;
    ey_nxt     = ey_r;
    push       = 1'b0;
    do_emit    = 1'b0;
    cmd        = '0;
    cmd.widx   = weight_index;
    cmd.wval   = weight_value;
    cmd.pix    = {side_in, blue_in, green_in, red_in};
    cmd.addr   = recv_r[LINE_AW-1:0];
    cmd.px     = ex_r;
    cmd.py     = ey_r;
    cmd.last   = (emit_inc == total);
    if (cfg_we && cfg_index <= REG_KSIZE) begin
      unique case (cfg_index)
        REG_WIDTH:  width_nxt  = cfg_data;
        REG_HEIGHT: height_nxt = cfg_data;
        REG_KSIZE:  ksize_nxt  = cfg_data[2:0];
        default:    ;
      endcase
      recv_nxt = '0;
      emit_nxt = '0;
      ex_nxt   = '0;
      ey_nxt   = '0;
    end else if (acc_en) begin
      unique case (operation)
        OP_LOAD: begin
          if (weight_index < 6'(TABLE_DEPTH)) begin
            push     = 1'b1;
            cmd.kind = CMD_LOAD;
          end
        end
        OP_PIXEL: begin
          if (recv_r < total) begin
            push        = 1'b1;
            cmd.kind    = CMD_PIX;
            cmd.store   = 1'b1;
            cmd.produce = (recv_r >= lag);
            do_emit     = cmd.produce;
            recv_nxt    = recv_r + CNT_W'(1);
          end
        end
        OP_DRAIN: begin
          if (recv_r >= total && emit_r < total) begin
            push        = 1'b1;
            cmd.kind    = CMD_PIX;
            cmd.produce = 1'b1;
            do_emit     = 1'b1;
          end
        end
        default: ;
      endcase
      if (do_emit) begin
        emit_nxt = emit_inc;
        if (11'(ex_r) + 11'd1 == cfg.w) begin
          ex_nxt = '0;
          ey_nxt = ey_r + CRD_W'(1);
        end else begin
          ex_nxt = ex_r + CRD_W'(1);
        end
        // frame done: restart the receive, emit and coordinate counters
        if (emit_inc >= total) begin
          recv_nxt = '0;
          emit_nxt = '0;
          ex_nxt   = '0;
          ey_nxt   = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 11'(MAX_WIDTH);
      height_r <= 11'(MAX_HEIGHT);
      ksize_r  <= 3'd3;
      recv_r   <= '0;
      emit_r   <= '0;
      ex_r     <= '0;
      ey_r     <= '0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      ksize_r  <= ksize_nxt;
      recv_r   <= recv_nxt;
      emit_r   <= emit_nxt;
      ex_r     <= ex_nxt;
      ey_r     <= ey_nxt;
    end
  end
endmodule

>>> hw/rtl/rkc_queue.sv
// Two-entry command queue between front and back.
module rkc_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rkc_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output rkc_pkg::cmd_t head
);
  import rkc_pkg::*;

  cmd_t       ent_r [2];
  logic       wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head      = ent_r[rptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wptr_nxt = do_push ? ~wptr_r : wptr_r;
    rptr_nxt = do_pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wptr_r] <= push_cmd;
    end
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end
endmodule

>>> hw/rtl/rkc_back.sv
// Back end: line store, weight table, tap sequencer, multiply-accumulate, output register.
module rkc_back (
  input  logic          clk,
  input  logic          rst_n,
  input  rkc_pkg::cfg_t cfg,
  input  logic          q_valid,
  input  rkc_pkg::cmd_t q_cmd,
  output logic          q_pop,
  rkc_out_if.source     out_ch
);
  import rkc_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_TAP  = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [2:0]          ky_r, ky_nxt, kx_r, kx_nxt;
  logic [TABLE_AW-1:0] kidx_r, kidx_nxt;
  logic [CRD_W-1:0]    px_r, py_r;
  logic                last_r;
  logic [TABLE_DEPTH-1:0] kvalid_r;

  logic                line_we, kern_we, tap_last, tap_ctr, tap_issue;
  logic [PIX_W-1:0]    line_q;
  logic [17:0]         kern_q;
  logic [LINE_AW-1:0]  tap_addr;
  logic signed [12:0]  ty, tx;
  logic [CRD_W-1:0]    ny, nx;
  logic [20:0]         row_base;

  logic                s1_v, s1_last, s1_ctr, s1_kv;
  logic                s2_v, s2_last;
  logic signed [PROD_W-1:0] prod_r [3];
  logic signed [ACC_W-1:0]  acc_r [3];
  logic [15:0]         side_r;
  logic signed [17:0]  wt;

  logic                out_valid_r, out_valid_nxt, out_load;
  logic [7:0]          ch_sat [3];
  logic [7:0]          ch_r [3];
  logic [15:0]         oside_r;
  logic                olast_r;

  assign line_we = (state_r == S_IDLE) && q_valid && q_cmd.kind == CMD_PIX && q_cmd.store;
  assign kern_we = (state_r == S_IDLE) && q_valid && q_cmd.kind == CMD_LOAD;
  assign q_pop   = (state_r == S_IDLE) && q_valid;

  // clamp tap coordinates into the frame (border replicate)
  always_comb begin
    ty = $signed({3'b0, py_r}) + $signed({10'b0, ky_r}) - $signed({11'b0, cfg.r});
    tx = $signed({3'b0, px_r}) + $signed({10'b0, kx_r}) - $signed({11'b0, cfg.r});
    if (ty < 0) begin
      ny = '0;
    end else if (ty > $signed({2'b0, cfg.h} - 13'd1)) begin
      ny = CRD_W'(cfg.h - 11'd1);
    end else begin
      ny = ty[CRD_W-1:0];
    end
    if (tx < 0) begin
      nx = '0;
    end else if (tx > $signed({2'b0, cfg.w} - 13'd1)) begin
      nx = CRD_W'(cfg.w - 11'd1);
    end else begin
      nx = tx[CRD_W-1:0];
    end
    row_base = ny * cfg.w;
    tap_addr = LINE_AW'(row_base + 21'(nx));
  end

  assign tap_issue = (state_r == S_TAP);
  assign tap_last  = (ky_r == cfg.ks - 3'd1) && (kx_r == cfg.ks - 3'd1);
  assign tap_ctr   = (ky_r == 3'(cfg.r)) && (kx_r == 3'(cfg.r));

  rkc_ram #(.WIDTH(PIX_W), .DEPTH(LINE_DEPTH)) u_line (
    .clk   (clk),
    .we    (line_we),
    .waddr (q_cmd.addr),
    .wdata (q_cmd.pix),
    .raddr (tap_addr),
    .rdata (line_q)
  );

  rkc_ram #(.WIDTH(18), .DEPTH(TABLE_DEPTH)) u_kern (
    .clk   (clk),
    .we    (kern_we),
    .waddr (q_cmd.widx),
    .wdata (q_cmd.wval),
    .raddr (kidx_r),
    .rdata (kern_q)
  );

  always_comb begin
    state_nxt = state_r;
    ky_nxt    = ky_r;
    kx_nxt    = kx_r;
    kidx_nxt  = kidx_r;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid && q_cmd.kind == CMD_PIX && q_cmd.produce) begin
          state_nxt = S_TAP;
          ky_nxt    = '0;
          kx_nxt    = '0;
          kidx_nxt  = '0;
        end
      end
      S_TAP: begin
        kidx_nxt = kidx_r + TABLE_AW'(1);
        if (kx_r == cfg.ks - 3'd1) begin
          kx_nxt = '0;
          ky_nxt = ky_r + 3'd1;
        end else begin
          kx_nxt = kx_r + 3'd1;
        end
        if (tap_last) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (s2_v && s2_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign wt = s1_kv ? $signed(kern_q) : 18'sd0;

  // truncate toward zero, then saturate to a byte
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (acc_r[c] <= 0) begin
        ch_sat[c] = 8'd0;
      end else if (acc_r[c][ACC_W-1:WFRAC] > 17'd255) begin
        ch_sat[c] = 8'd255;
      end else begin
        ch_sat[c] = acc_r[c][WFRAC+7:WFRAC];
      end
    end
  end

  assign out_load = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && q_valid) begin
      px_r   <= q_cmd.px;
      py_r   <= q_cmd.py;
      last_r <= q_cmd.last;
    end
    s1_last <= tap_last;
    s1_ctr  <= tap_ctr;
    s1_kv   <= kvalid_r[kidx_r];
    s2_last <= s1_last;
    for (int c = 0; c < 3; c++) begin
      prod_r[c] <= wt * $signed({1'b0, line_q[8*c +: 8]});
      if (state_r == S_IDLE) begin
        acc_r[c] <= '0;
      end else if (s2_v) begin
        acc_r[c] <= acc_r[c] + ACC_W'(prod_r[c]);
      end
    end
    if (s1_v && s1_ctr) begin
      side_r <= line_q[39:24];
    end
    if (out_load) begin
      for (int c = 0; c < 3; c++) begin
        ch_r[c] <= ch_sat[c];
      end
      oside_r <= side_r;
      olast_r <= last_r;
    end
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ky_r        <= '0;
      kx_r        <= '0;
      kidx_r      <= '0;
      kvalid_r    <= '0;
      s1_v        <= 1'b0;
      s2_v        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ky_r        <= ky_nxt;
      kx_r        <= kx_nxt;
      kidx_r      <= kidx_nxt;
      s1_v        <= tap_issue;
      s2_v        <= s1_v;
      out_valid_r <= out_valid_nxt;
      if (kern_we) begin
        kvalid_r[q_cmd.widx] <= 1'b1;
      end
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.red_out    = ch_r[0];
  assign out_ch.green_out  = ch_r[1];
  assign out_ch.blue_out   = ch_r[2];
  assign out_ch.side_out   = oside_r;
  assign out_ch.frame_last = olast_r;
endmodule

>>> hw/rtl/rgb_kernel_convolution_clamped.sv
// Top level of the streaming RGB convolution with replicated borders.
// Usage:
//   Write the width, height and kernel side registers on the cfg_ port while idle; a write
//   to one of them restarts the frame. Load weights (operation 0) before the frame, then send
//   pixels (operation 1) in raster order on in_ch. The back end starts the result for pixel p
//   once pixel p + radius*width + radius is taken; after the last pixel, each
//   drain item (operation 2) releases one pending result. frame_last marks the final one.
// Processing:
//   Loads and pixels that give no result are consumed by the back end in its idle state.
//   A pixel with a result goes through a dispatch step, then one tap per cycle reading a
//   line-store entry and a weight, a wait while the multiply and accumulate stages drain,
//   and the output register load. A two-entry queue lets the front keep taking items
//   while the back end works.
// Reset:
//   Registers return to 1024 x 1024 with a 3 x 3 kernel, weights read as zero, counters
//   clear. The line store is not cleared.
// Stall:
//   When out_ch.ready is low the result holds in the output register, the back end stops
//   once its next result is ready, and in_ch.ready falls when the queue fills.
module rgb_kernel_convolution_clamped (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data,
  rkc_in_if.sink      in_ch,
  rkc_out_if.source   out_ch
);
  import rkc_pkg::*;

  cfg_t cfg;
  cmd_t push_cmd, head;
  logic push, full, pop, not_empty, acc_en;

  assign in_ch.ready = !full;
  assign acc_en      = in_ch.valid && !full;

  rkc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .acc_en       (acc_en),
    .operation    (in_ch.operation),
    .weight_index (in_ch.weight_index),
    .weight_value (in_ch.weight_value),
    .red_in       (in_ch.red_in),
    .green_in     (in_ch.green_in),
    .blue_in      (in_ch.blue_in),
    .side_in      (in_ch.side_in),
    .cfg          (cfg),
    .push         (push),
    .cmd          (push_cmd)
  );

  rkc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  rkc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_valid (not_empty),
    .q_cmd   (head),
    .q_pop   (pop),
    .out_ch  (out_ch)
  );
endmodule
